>>> rtl/wsg_pkg.sv
// Shared constants, stage types and the arctangent table of the windowed sine generator.
`default_nettype none
package wsg_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  // One divider cell per bit of the 64-bit dividend {d, 32'b0}.
  localparam int DIV_CELLS = 64;

  localparam logic [30:0]        PERIOD_PI     = 31'd205887;
  localparam logic signed [31:0] TURNS_PER_RAD = 32'sd683565276;
  localparam logic signed [31:0] HALF_PI_Q30   = 32'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN   = 34'sd652032874;

  typedef enum logic [2:0] {
    REG_START  = 3'd0,
    REG_FINISH = 3'd1,
    REG_PERIOD = 3'd2,
    REG_PHASE  = 3'd3,
    REG_AMP    = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic        vld;
    logic        win;
    logic [31:0] dvd;
    logic [30:0] rem;
    logic [31:0] quo;
  } div_stage_t;

  typedef struct packed {
    logic               vld;
    logic               win;
    logic [1:0]         quad;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
  } cordic_stage_t;

  function automatic logic signed [32:0] atan_q30(input int idx);
    logic signed [32:0] a;
    case (idx)
      0:  a = 33'sd843314857;
      1:  a = 33'sd497837829;
      2:  a = 33'sd263043837;
      3:  a = 33'sd133525159;
      4:  a = 33'sd67021687;
      5:  a = 33'sd33543516;
      6:  a = 33'sd16775851;
      7:  a = 33'sd8388437;
      8:  a = 33'sd4194283;
      9:  a = 33'sd2097149;
      10: a = 33'sd1048576;
      11: a = 33'sd524288;
      12: a = 33'sd262144;
      13: a = 33'sd131072;
      14: a = 33'sd65536;
      15: a = 33'sd32768;
      16: a = 33'sd16384;
      17: a = 33'sd8192;
      18: a = 33'sd4096;
      19: a = 33'sd2048;
      20: a = 33'sd1024;
      21: a = 33'sd512;
      22: a = 33'sd256;
      23: a = 33'sd128;
      24: a = 33'sd64;
      25: a = 33'sd32;
      26: a = 33'sd16;
      27: a = 33'sd8;
      28: a = 33'sd4;
      29: a = 33'sd2;
      30: a = 33'sd1;
      default: a = 33'sd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

>>> rtl/windowed_sine_generator_core.sv
// Top level of the windowed sine generator: window check, divider chain, CORDIC chain, scaling.
//
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+------------------------------------
// in       | input     | in_valid_i / in_ready_o | time_sample_i
// out      | output    | out_valid_o/out_ready_i | factor_value_o, in_window_o
// cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One beat is accepted per cycle while the skid register is empty; the pipeline is made of
// the 64-cell divider chain, the CORDIC chain and six single-register stages around them.
// Reset clears all valid flags and loads the register defaults; no clearing pass is needed.
// A stalled output beat moves into a one-entry skid register; the whole pipeline then
// holds, and in_ready_o drops, until the skid register drains.
// Configuration writes are always accepted.
`default_nettype none
module windowed_sine_generator_core
  import wsg_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] time_sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] factor_value_o,
  output logic        in_window_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  // Configuration registers. The user must change them only while the pipeline is empty,
  // which the block does not enforce; every stage reads them directly, with no copy per beat.
  logic signed [31:0] start_q, finish_q, phase_q, amp_q;
  logic [30:0]        period_q;
  logic [31:0]        sturn_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      finish_q <= '0;
      period_q <= 31'd65536;
      phase_q  <= '0;
      amp_q    <= 32'sd65536;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_START:  start_q  <= cfg_data_i;
        REG_FINISH: finish_q <= cfg_data_i;
        REG_PERIOD: period_q <= cfg_data_i[30:0];
        REG_PHASE:  phase_q  <= cfg_data_i;
        REG_AMP:    amp_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The phase offset in turns is a pure function of the phase register; it is
  // recomputed every cycle, long before any beat reaches the phase adder.
  logic signed [62:0] sprod;
  assign sprod = phase_q * TURNS_PER_RAD;

  always_ff @(posedge clk_i) begin
    sturn_q <= sprod[47:16];
  end

  logic [30:0] period_eff;
  assign period_eff = (period_q == '0) ? PERIOD_PI : period_q;

  // Global advance: the pipeline moves whenever the skid register is empty.
  logic skid_vld_q;
  logic en;
  assign en         = !skid_vld_q;
  assign in_ready_o = en;

  // Entry stage: window compare and offset from the window start.
  div_stage_t  dst [DIV_CELLS+1];
  div_stage_t  s0_d, s0_q;
  logic [31:0] diff_t;

  always_comb begin
    diff_t   = time_sample_i - start_q;
    s0_d.vld = in_valid_i && en;
    s0_d.win = ($signed(time_sample_i) >= start_q) && ($signed(time_sample_i) <= finish_q);
    s0_d.dvd = diff_t;
    s0_d.rem = '0;
    s0_d.quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= '0;
    end else if (en) begin
      s0_q <= s0_d;
    end
  end

  assign dst[0] = s0_q;

  // Divider chain. The first 32 cells reduce the offset modulo the period, the last 32
  // produce the fraction of a turn; the low 32 quotient bits are the time phase.
  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
    wsg_div_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .divisor_i (period_eff),
      .stage_i   (dst[k]),
      .stage_o   (dst[k+1])
    );
  end

  // Phase stage: add the offset, split into quadrant and centered residual.
  logic               ph_vld_q, ph_win_q;
  logic [1:0]         ph_quad_q;
  logic signed [30:0] ph_r_q;
  logic [31:0]        phase_sum, phase_rot;
  logic signed [30:0] resid;

  always_comb begin
    phase_sum = dst[DIV_CELLS].quo + sturn_q;
    phase_rot = phase_sum + 32'h2000_0000;
    resid     = $signed({1'b0, phase_rot[29:0]}) - 31'sd536870912;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_vld_q <= 1'b0;
    end else if (en) begin
      ph_vld_q <= dst[DIV_CELLS].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ph_win_q  <= dst[DIV_CELLS].win;
      ph_quad_q <= phase_rot[31:30];
      ph_r_q    <= resid;
    end
  end

  // Angle stage: residual turns to radians in Q2.30, then seeds the CORDIC chain.
  cordic_stage_t      cst [CORDIC_STAGES+1];
  cordic_stage_t      z_q;
  logic signed [62:0] zprod;

  assign zprod = ph_r_q * HALF_PI_Q30;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_q <= '0;
    end else if (en) begin
      z_q.vld  <= ph_vld_q;
      z_q.win  <= ph_win_q;
      z_q.quad <= ph_quad_q;
      z_q.x    <= CORDIC_GAIN;
      z_q.y    <= '0;
      z_q.z    <= zprod[62:30];
    end
  end

  assign cst[0] = z_q;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    wsg_cordic_cell #(
      .SHIFT (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (cst[k]),
      .stage_o (cst[k+1])
    );
  end

  // Quadrant stage: pick the sine from the rotated vector.
  logic               sn_vld_q, sn_win_q;
  logic signed [33:0] sn_q, sine;

  always_comb begin
    unique case (cst[CORDIC_STAGES].quad)
      2'd0: sine = cst[CORDIC_STAGES].y;
      2'd1: sine = cst[CORDIC_STAGES].x;
      2'd2: sine = -cst[CORDIC_STAGES].y;
      2'd3: sine = -cst[CORDIC_STAGES].x;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sn_vld_q <= 1'b0;
    end else if (en) begin
      sn_vld_q <= cst[CORDIC_STAGES].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sn_win_q <= cst[CORDIC_STAGES].win;
      sn_q     <= sine;
    end
  end

  // Scaling stage: amplitude times sine.
  logic               mu_vld_q, mu_win_q;
  logic signed [65:0] mu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_vld_q <= 1'b0;
    end else if (en) begin
      mu_vld_q <= sn_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mu_win_q <= sn_win_q;
      mu_q     <= amp_q * sn_q;
    end
  end

  // Round to Q16.16, saturate, and force zero outside the window.
  logic signed [65:0] rnd;
  logic signed [35:0] scaled;
  logic [31:0]        fin_val;

  always_comb begin
    rnd    = mu_q + 66'sd536870912;
    scaled = rnd[65:30];
    if (!mu_win_q) begin
      fin_val = '0;
    end else if (scaled > 36'sd2147483647) begin
      fin_val = 32'h7FFF_FFFF;
    end else if (scaled < -36'sd2147483648) begin
      fin_val = 32'h8000_0000;
    end else begin
      fin_val = scaled[31:0];
    end
  end

  // Output register with a one-entry skid register behind it.
  logic        out_vld_q, out_win_q, skid_win_q;
  logic [31:0] out_val_q, skid_val_q;
  logic        slot_free;

  assign slot_free = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (skid_vld_q) begin
        if (out_ready_i) begin
          skid_vld_q <= 1'b0;
        end
      end else if (mu_vld_q) begin
        if (slot_free) begin
          out_vld_q <= 1'b1;
        end else begin
          skid_vld_q <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_ready_i) begin
        out_val_q <= skid_val_q;
        out_win_q <= skid_win_q;
      end
    end else if (mu_vld_q) begin
      if (slot_free) begin
        out_val_q <= fin_val;
        out_win_q <= mu_win_q;
      end else begin
        skid_val_q <= fin_val;
        skid_win_q <= mu_win_q;
      end
    end
  end

  assign out_valid_o    = out_vld_q;
  assign factor_value_o = out_val_q;
  assign in_window_o    = out_win_q;

endmodule
`default_nettype wire

>>> rtl/wsg_div_cell.sv
// One restoring division step: shifts in a dividend bit and produces one quotient bit.
`default_nettype none
module wsg_div_cell
  import wsg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [30:0] divisor_i,
  input  div_stage_t  stage_i,
  output div_stage_t  stage_o
);

  div_stage_t  stage_d, stage_q;
  logic [31:0] rem2;
  logic [31:0] diff;
  logic        ge;

  always_comb begin
    rem2 = {stage_i.rem, stage_i.dvd[31]};
    diff = rem2 - {1'b0, divisor_i};
    ge   = rem2 >= {1'b0, divisor_i};
    stage_d     = stage_i;
    stage_d.dvd = {stage_i.dvd[30:0], 1'b0};
    stage_d.rem = ge ? diff[30:0] : rem2[30:0];
    stage_d.quo = {stage_i.quo[30:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule
`default_nettype wire

>>> rtl/wsg_cordic_cell.sv
// One rotation-mode CORDIC iteration with a fixed shift.
`default_nettype none
module wsg_cordic_cell
  import wsg_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  cordic_stage_t stage_i,
  output cordic_stage_t stage_o
);

  cordic_stage_t      stage_d, stage_q;
  logic signed [33:0] dx, dy;
  logic signed [32:0] ang;

  always_comb begin
    dx  = $signed(stage_i.y) >>> SHIFT;
    dy  = $signed(stage_i.x) >>> SHIFT;
    ang = atan_q30(SHIFT);
    stage_d = stage_i;
    if (!stage_i.z[32]) begin
      stage_d.x = stage_i.x - dx;
      stage_d.y = stage_i.y + dy;
      stage_d.z = stage_i.z - ang;
    end else begin
      stage_d.x = stage_i.x + dx;
      stage_d.y = stage_i.y - dy;
      stage_d.z = stage_i.z + ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule
`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench of the windowed sine generator core.
`default_nettype none
module tb
  import wsg_pkg::*;
;

  // The block takes one time sample per beat and returns one factor beat for it.
  // The scoreboard below keeps its own copy of the five registers and predicts every
  // factor with a bit-exact model of the divider, the turn conversion, the CORDIC and
  // the saturating scale.
  localparam int STAGES  = CORDIC_STAGES_DEF;
  localparam int LATENCY = STAGES + 70;

  // Indexes that name no register; writes to them must change nothing.
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic [31:0] factor;
    logic        win;
  } factor_beat_t;

  class factor_scoreboard;
    longint start_q, finish_q, phase_q, amp_q;
    longint unsigned period_q;
    factor_beat_t factor_expected[$];
    int errors;
    longint arctan[16] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                           33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                           524288, 262144, 131072, 65536, 32768};

    function new();
      start_q  = 0;
      finish_q = 0;
      period_q = 65536;
      phase_q  = 0;
      amp_q    = 65536;
      errors   = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_START:  start_q  = longint'($signed(v));
        REG_FINISH: finish_q = longint'($signed(v));
        REG_PERIOD: period_q = longint'({1'b0, v[30:0]});
        REG_PHASE:  phase_q  = longint'($signed(v));
        REG_AMP:    amp_q    = longint'($signed(v));
        default: ;  // Writes to unused indexes leave every register alone.
      endcase
    endfunction

    // Sine in Q2.30 for a phase given in turns (Q0.32).
    function longint sine_of_phase(logic [31:0] turns);
      logic [31:0] shifted;
      longint r, x, y, z, dx, dy;
      shifted = turns + 32'h2000_0000;
      r = longint'({2'b00, shifted[29:0]}) - 64'sd536870912;
      z = (r * 64'sd1686629713) >>> 30;
      x = 64'sd652032874;
      y = 0;
      for (int i = 0; i < STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - arctan[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + arctan[i];
        end
      end
      case (shifted[31:30])
        2'd0: return y;
        2'd1: return x;
        2'd2: return -y;
        default: return -x;
      endcase
    endfunction

    function void note_sample(logic [31:0] t);
      factor_beat_t e;
      longint ts, prod;
      longint unsigned d, p, q;
      logic [63:0] shift_full;
      logic [31:0] tturn;
      ts = longint'($signed(t));
      e.factor = '0;
      e.win    = 1'b0;
      if (ts >= start_q && ts <= finish_q) begin
        d = longint'(ts - start_q);
        // A zero period stands for pi.
        p = (period_q != 0) ? period_q : 64'd205887;
        q = ((d % p) << 32) / p;
        tturn = q[31:0];
        shift_full = phase_q * 64'sd683565276;
        prod = (amp_q * sine_of_phase(tturn + shift_full[47:16]) + 64'sd536870912) >>> 30;
        if (prod > 64'sd2147483647) prod = 64'sd2147483647;
        if (prod < -64'sd2147483648) prod = -64'sd2147483648;
        e.factor = prod[31:0];
        e.win    = 1'b1;
      end
      factor_expected.push_back(e);
    endfunction

    function void check_factor(logic [31:0] f, logic w);
      factor_beat_t e;
      if (factor_expected.size() == 0) begin
        $error("factor beat with no sample waiting: factor_value %h", f);
        errors++;
        return;
      end
      e = factor_expected.pop_front();
      if (f !== e.factor) begin
        $error("factor_value expected %h actual %h", e.factor, f);
        errors++;
      end
      if (w !== e.win) begin
        $error("in_window expected %b actual %b", e.win, w);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] time_sample_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] factor_value_o;
  logic        in_window_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  factor_scoreboard sb = new();

  // Idle percentages of the two sides, and a long receiver hold-off requested by the
  // main process and counted down in the receiver process.
  int send_idle = 0;
  int recv_idle = 0;
  int hold_cycles = 0;

  windowed_sine_generator_core DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .time_sample_i,
    .out_valid_o, .out_ready_i, .factor_value_o, .in_window_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Both monitors sample at the edge, before the block's own updates of that edge land.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_sample(time_sample_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_factor(factor_value_o, in_window_o);
  end

  // Receiver: random back-pressure, overridden by a long hold-off when one is asked for.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin
    #(8 * 3000000);
    $display("windowed_sine_generator_core: mismatch");
    $finish;
  end

  // Offers one time sample; valid stays high between back-to-back beats.
  task automatic send_sample(input logic [31:0] v);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    time_sample_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.factor_expected.size() != 0) @(posedge clk_i);
  endtask

  // Register writes happen only with the pipeline empty.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    drain();
    repeat (LATENCY + 4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, v);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(input logic [31:0] s, input logic [31:0] f,
                           input logic [31:0] per, input logic [31:0] ph,
                           input logic [31:0] amp);
    write_reg(REG_START, s);
    write_reg(REG_FINISH, f);
    write_reg(REG_PERIOD, per);
    write_reg(REG_PHASE, ph);
    write_reg(REG_AMP, amp);
  endtask

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  logic [31:0] cfg_shadow_start, cfg_shadow_finish;

  // Mostly samples inside or at the edges of the window, with some full-range noise.
  function automatic logic [31:0] pick_sample();
    longint s, f, span;
    int sel;
    s = longint'($signed(cfg_shadow_start));
    f = longint'($signed(cfg_shadow_finish));
    sel = $urandom_range(99);
    if (f >= s && sel < 70) begin
      span = f - s + 1;
      return 32'(s + longint'({$urandom(), $urandom()} % longint'(span)));
    end
    case (sel % 5)
      0: return 32'(s);
      1: return 32'(f);
      2: return 32'(s - 1);
      3: return 32'(f + 1);
      default: return $urandom();
    endcase
  endfunction

  task automatic random_config();
    longint s, w;
    s = longint'($signed(pick_extreme()));
    if ($urandom_range(9) == 0) s = longint'($signed($urandom()));
    // Windows mostly narrow enough to hit, sometimes empty or reaching the top.
    case ($urandom_range(4))
      0: w = -longint'($urandom_range(1000, 1));
      1: w = 64'h7fff_ffff;
      default: w = longint'($urandom_range(32'h0100_0000));
    endcase
    if (s + w > 64'sd2147483647) w = 64'sd2147483647 - s;
    if (s + w < -64'sd2147483648) w = -64'sd2147483648 - s;
    cfg_shadow_start  = 32'(s);
    cfg_shadow_finish = 32'(s + w);
    write_all(cfg_shadow_start, cfg_shadow_finish,
              ($urandom_range(3) == 0) ? {1'($urandom_range(1)), 31'd0} :
              ($urandom_range(1) ? $urandom() : $urandom_range(32'h0004_0000, 1)),
              pick_extreme(), ($urandom_range(3) == 0) ? pick_extreme() : $urandom());
  endtask

  initial begin
    cfg_shadow_start  = '0;
    cfg_shadow_finish = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: the window holds only time zero.
    send_sample(32'h0000_0000);
    send_sample(32'h0000_0001);
    send_sample(32'hffff_ffff);
    send_sample(32'h8000_0000);
    send_sample(32'h7fff_ffff);

    // Widest window, zero period, largest amplitude: the product saturates both ways.
    cfg_shadow_start  = 32'h8000_0000;
    cfg_shadow_finish = 32'h7fff_ffff;
    write_all(cfg_shadow_start, cfg_shadow_finish, 32'h8000_0000, 32'h0001_0000,
              32'h7fff_ffff);
    write_reg(REG_SPARE_LO, 32'hdead_beef);
    write_reg(REG_SPARE_HI, 32'h1234_5678);
    send_sample(32'h8000_0000);
    send_sample(32'h7fff_ffff);
    send_sample(32'h0000_0000);
    send_sample(32'h0001_9221);
    write_reg(REG_AMP, 32'h8000_0000);
    write_reg(REG_PHASE, 32'h8000_0000);
    send_sample(32'h0000_0000);
    send_sample(32'h0003_243f);
    write_reg(REG_PHASE, 32'h7fff_ffff);
    write_reg(REG_PERIOD, 32'h7fff_ffff);
    send_sample(32'h7fff_ffff);
    send_sample(32'hc000_0000);

    // Empty window: finish lies before start.
    cfg_shadow_start  = 32'h0000_1000;
    cfg_shadow_finish = 32'h0000_0fff;
    write_reg(REG_START, cfg_shadow_start);
    write_reg(REG_FINISH, cfg_shadow_finish);
    send_sample(32'h0000_1000);
    send_sample(32'h0000_0fff);
    send_sample(32'h0000_0800);

    // Random phases; the idle pattern follows the three-part schedule. The hold-off
    // phase offers more beats than the pipeline holds, so the input stalls under it.
    for (int ph = 0; ph < 9; ph++) begin
      int n_items;
      n_items = (ph == 7) ? 120 : 60;
      send_idle = (ph < 3) ? 34 : (ph < 6) ? 83 : 0;
      recv_idle = (ph < 3) ? 83 : (ph < 6) ? 34 : 0;
      random_config();
      for (int n = 0; n < n_items; n++) begin
        if (ph == 7 && n == 10) hold_cycles = 3 * LATENCY;  // fill the pipeline
        if (ph == 8 && n == 30) drain();  // sender waits until every factor is back
        send_sample(pick_sample());
      end
    end

    in_valid_i <= 1'b0;
    drain();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (sb.errors == 0 && sb.factor_expected.size() == 0) begin
      $display("windowed_sine_generator_core: match");
    end else begin
      $display("windowed_sine_generator_core: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
rtl/wsg_pkg.sv
rtl/wsg_div_cell.sv
rtl/wsg_cordic_cell.sv
rtl/windowed_sine_generator_core.sv
dv/tb.sv
